[hw/rtl/dsnc_pkg.sv]
// Shared types, constants and SHA-256 helper functions for the nonce checker.
// No dependencies.
package dsnc_pkg;

   localparam int unsigned NUM_ROUNDS = 64;
   localparam logic [31:0] MANT_MASK = 32'h007f_ffff;
   localparam logic [31:0] HEADER_BITS = 32'd640;
   localparam logic [31:0] HASH_BITS = 32'd256;
   localparam logic [7:0] EXP_BIAS = 8'd3;
   localparam logic [7:0] MAX_SHIFT = 8'd29;

   typedef enum logic [2:0] {
      CSR_MIDSTATE_A = 3'd0,
      CSR_MIDSTATE_B = 3'd1,
      CSR_MIDSTATE_C = 3'd2,
      CSR_MIDSTATE_D = 3'd3,
      CSR_HEADER_TAIL = 3'd4,
      CSR_COMPACT_TARGET = 3'd5
   } csr_index_type;

   typedef logic [7:0][31:0] state_type;   // [0] is word a
   typedef logic [15:0][31:0] sched_type;  // [0] is the word used this round

   // One slot of a compression chain.
   typedef struct packed {
      logic valid;
      logic [31:0] nonce;
      state_type work;
      state_type init;
      sched_type w;
   } slot_type;

   localparam logic [63:0][31:0] ROUND_K = {
      32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
      32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
      32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
      32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
      32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
      32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
      32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
      32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
      32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
      32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
      32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
      32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
      32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
      32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
      32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
      32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98};

   localparam state_type SHA_IV = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] bswap(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

endpackage

[hw/rtl/dsnc_round_cell.sv]
// One SHA-256 round cell: one round plus one schedule step, registered.
// Depends on dsnc_pkg.
module dsnc_round_cell #(
   parameter logic [31:0] K = 32'h0
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  dsnc_pkg::slot_type slot_in,
   output dsnc_pkg::slot_type slot_out
);
   import dsnc_pkg::*;

   slot_type slot_ff, slot_in_next;
   logic [31:0] a, b, c, d, e, f, g, h;
   logic [31:0] t1, t2, s0, s1, w_new;

   always_comb begin
      {h, g, f, e, d, c, b, a} = slot_in.work;
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + K + slot_in.w[0];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      s0 = rotr(slot_in.w[1], 7) ^ rotr(slot_in.w[1], 18) ^ (slot_in.w[1] >> 3);
      s1 = rotr(slot_in.w[14], 17) ^ rotr(slot_in.w[14], 19) ^ (slot_in.w[14] >> 10);
      w_new = slot_in.w[0] + s0 + slot_in.w[9] + s1;
      slot_in_next = slot_in;
      slot_in_next.work = {g, f, e, d + t1, c, b, a, t1 + t2};
      slot_in_next.w = {w_new, slot_in.w[15:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else if (advance) begin
         slot_ff.valid <= slot_in_next.valid;
      end
      if (advance) begin
         slot_ff.nonce <= slot_in_next.nonce;
         slot_ff.work <= slot_in_next.work;
         slot_ff.init <= slot_in_next.init;
         slot_ff.w <= slot_in_next.w;
      end
   end

   assign slot_out = slot_ff;
endmodule

[hw/rtl/dsnc_chain.sv]
// A 64-cell chain of SHA-256 rounds; cell outputs feed the next cell.
// Depends on dsnc_pkg and dsnc_round_cell.
module dsnc_chain (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  dsnc_pkg::slot_type slot_in,
   output dsnc_pkg::slot_type slot_out
);
   import dsnc_pkg::*;

   slot_type link [NUM_ROUNDS+1];

   assign link[0] = slot_in;

   for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_cell
      dsnc_round_cell #(.K(ROUND_K[r])) u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .slot_in(link[r]), .slot_out(link[r+1]));
   end

   assign slot_out = link[NUM_ROUNDS];
endmodule

[hw/rtl/double_sha256_nonce_check_top.sv]
// Double SHA-256 nonce checker.
// Load midstate, header tail and compact target through the csr_ channel
// (index 0..5, one transfer per register; other indexes are ignored) while
// no nonce is in flight. Each nonce transferred on req_ runs through two
// chains of 64 round cells, one for each compression, then a registered
// compare and the output register. One nonce is accepted every cycle
// while req_stall is low: every cell holds one item and hands it on each
// cycle the pipeline advances.
// When the receiver asserts rsp_stall with a result waiting, the whole
// pipeline holds and req_stall is raised; req_stall is low whenever the
// output register is empty or being drained.
// Synchronous reset empties the pipeline and loads register defaults
// (compact target 0x1d00ffff, all else zero).
// Results come in nonce order. The hash is little-endian, hash_q3 most
// significant; found is forced low when the target exponent is out of range.
// Depends on dsnc_pkg, dsnc_chain.
module double_sha256_nonce_check_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [31:0] req_nonce,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [31:0] rsp_nonce_echo,
   output logic rsp_found,
   output logic rsp_target_bad,
   output logic [63:0] rsp_hash_q3,
   output logic [63:0] rsp_hash_q2,
   output logic [63:0] rsp_hash_q1,
   output logic [63:0] rsp_hash_q0,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [63:0] csr_wdata
);
   import dsnc_pkg::*;

   logic [63:0] mid_a_ff, mid_b_ff, mid_c_ff, mid_d_ff, tail_ff;
   logic [31:0] bits_ff;
   logic advance;
   slot_type first_in, first_out, second_in, second_out;
   state_type h1, h2;
   logic [255:0] hash_le, target;
   logic [7:0] shift;
   logic bad;
   logic cmp_valid_ff;
   logic [31:0] cmp_nonce_ff;
   logic [255:0] cmp_hash_ff, cmp_target_ff;
   logic cmp_bad_ff;
   logic out_valid_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_a_ff <= '0; mid_b_ff <= '0; mid_c_ff <= '0; mid_d_ff <= '0;
         tail_ff <= '0; bits_ff <= 32'h1d00ffff;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIDSTATE_A: mid_a_ff <= csr_wdata;
            CSR_MIDSTATE_B: mid_b_ff <= csr_wdata;
            CSR_MIDSTATE_C: mid_c_ff <= csr_wdata;
            CSR_MIDSTATE_D: mid_d_ff <= csr_wdata;
            CSR_HEADER_TAIL: tail_ff <= csr_wdata;
            CSR_COMPACT_TARGET: bits_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // Hold the whole pipeline while a result waits under stall.
   assign advance = !(out_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      first_in.valid = req_valid;
      first_in.nonce = req_nonce;
      first_in.init = {mid_d_ff[31:0], mid_d_ff[63:32], mid_c_ff[31:0], mid_c_ff[63:32],
                       mid_b_ff[31:0], mid_b_ff[63:32], mid_a_ff[31:0], mid_a_ff[63:32]};
      first_in.work = first_in.init;
      first_in.w = {HEADER_BITS, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                    32'h0, 32'h0, 32'h0, 32'h8000_0000, bswap(req_nonce),
                    bswap(bits_ff), tail_ff[31:0], tail_ff[63:32]};
   end

   dsnc_chain u_first (.clock(clock), .reset(reset), .advance(advance),
                       .slot_in(first_in), .slot_out(first_out));

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         h1[i] = first_out.init[i] + first_out.work[i];
      end
      second_in.valid = first_out.valid;
      second_in.nonce = first_out.nonce;
      second_in.init = SHA_IV;
      second_in.work = SHA_IV;
      second_in.w = {HASH_BITS, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                     32'h8000_0000, h1};
   end

   dsnc_chain u_second (.clock(clock), .reset(reset), .advance(advance),
                        .slot_in(second_in), .slot_out(second_out));

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         h2[i] = second_out.init[i] + second_out.work[i];
         hash_le[32*i +: 32] = bswap(h2[i]);
      end
      shift = bits_ff[31:24] - EXP_BIAS;
      bad = (bits_ff[31:24] < EXP_BIAS) || (shift > MAX_SHIFT);
      target = {232'h0, (bits_ff[23:0] & MANT_MASK[23:0])} << {shift[4:0], 3'b000};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         cmp_valid_ff <= second_out.valid;
         out_valid_ff <= cmp_valid_ff;
      end
      if (advance) begin
         cmp_nonce_ff <= second_out.nonce;
         cmp_hash_ff <= hash_le;
         cmp_target_ff <= target;
         cmp_bad_ff <= bad;
         rsp_nonce_echo <= cmp_nonce_ff;
         rsp_found <= !cmp_bad_ff && (cmp_hash_ff <= cmp_target_ff);
         rsp_target_bad <= cmp_bad_ff;
         rsp_hash_q3 <= cmp_hash_ff[255:192];
         rsp_hash_q2 <= cmp_hash_ff[191:128];
         rsp_hash_q1 <= cmp_hash_ff[127:64];
         rsp_hash_q0 <= cmp_hash_ff[63:0];
      end
   end

   assign rsp_valid = out_valid_ff;
endmodule

[hw/rtl/dsnc_checker.sv]
// Port-level checks for the nonce checker, bound to the top level.
// Depends on double_sha256_nonce_check_top.
module dsnc_checker (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_found,
   input logic rsp_target_bad,
   input logic [31:0] rsp_nonce_echo
);
   a_found_not_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_target_bad)) else $error("found with bad target");
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall) else $error("input stalled without cause");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_nonce_echo))
      else $error("stalled result changed");
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("result right after reset");
endmodule

bind double_sha256_nonce_check_top dsnc_checker u_dsnc_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_found(rsp_found),
   .rsp_target_bad(rsp_target_bad), .rsp_nonce_echo(rsp_nonce_echo));

[sim/double_sha256_nonce_check_top_tb.sv]
// Testbench for double_sha256_nonce_check_top: drives nonces and register writes,
// predicts each double SHA-256 result and checks it. Depends on dsnc_pkg and the RTL.
`timescale 1ns / 100ps

module double_sha256_nonce_check_top_tb;
   import dsnc_pkg::*;

   typedef bit [7:0][31:0] hash_words_type;
   typedef bit [15:0][31:0] block_words_type;

   typedef struct {
      bit [31:0] nonce;
      bit found;
      bit target_bad;
      bit [63:0] q3, q2, q1, q0;
   } nonce_result_type;

   localparam logic [2:0] CSR_UNUSED_6 = 3'd6;
   localparam logic [2:0] CSR_UNUSED_7 = 3'd7;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 140;

   localparam bit [63:0][31:0] SHA_K = {
      32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
      32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
      32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
      32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
      32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
      32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
      32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
      32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
      32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
      32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
      32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
      32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
      32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
      32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
      32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
      32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98};

   localparam hash_words_type START_IV = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   logic clock, reset;
   logic req_valid, req_stall;
   logic [31:0] req_nonce;
   logic rsp_valid, rsp_stall;
   logic [31:0] rsp_nonce_echo;
   logic rsp_found, rsp_target_bad;
   logic [63:0] rsp_hash_q3, rsp_hash_q2, rsp_hash_q1, rsp_hash_q0;
   logic csr_valid, csr_ready;
   logic [2:0] csr_index;
   logic [63:0] csr_wdata;

   // shadow copy of the register file
   bit [63:0] midstate_regs [4];
   bit [63:0] tail_reg;
   bit [31:0] target_bits;

   nonce_result_type pending_results [$];
   int errors = 0;
   int checked = 0;
   int found_count = 0;
   int bad_count = 0;
   int cycles = 0;
   bit quiet = 0;

   double_sha256_nonce_check_top i_dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic bit [31:0] ror32(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic hash_words_type sha_block(hash_words_type h, block_words_type blk);
      bit [31:0] w [64];
      hash_words_type v;
      bit [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      v = h;
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) h[i] = h[i] + v[i];
      return h;
   endfunction

   function automatic nonce_result_type scan_nonce(bit [31:0] nonce);
      nonce_result_type r;
      hash_words_type h;
      block_words_type blk;
      bit [255:0] hash_le, limit_le;
      int shift;
      for (int i = 0; i < 4; i++) begin
         h[2*i] = midstate_regs[i][63:32];
         h[2*i+1] = midstate_regs[i][31:0];
      end
      blk = '0;
      blk[0] = tail_reg[63:32];
      blk[1] = tail_reg[31:0];
      blk[2] = {target_bits[7:0], target_bits[15:8], target_bits[23:16], target_bits[31:24]};
      blk[3] = {nonce[7:0], nonce[15:8], nonce[23:16], nonce[31:24]};
      blk[4] = 32'h8000_0000;
      blk[15] = 32'd640;
      h = sha_block(h, blk);
      blk = '0;
      for (int i = 0; i < 8; i++) blk[i] = h[i];
      blk[8] = 32'h8000_0000;
      blk[15] = 32'd256;
      h = sha_block(START_IV, blk);
      // digest bytes in stream order become the integer from byte 0 upward
      for (int i = 0; i < 8; i++)
         for (int b = 0; b < 4; b++)
            hash_le[8*(4*i+b) +: 8] = h[i][31-8*b -: 8];
      shift = int'(target_bits[31:24]) - 3;
      r.target_bad = (shift < 0 || shift > 29);
      limit_le = '0;
      if (!r.target_bad) limit_le[8*shift +: 24] = {1'b0, target_bits[22:0]};
      r.nonce = nonce;
      r.found = !r.target_bad && (hash_le <= limit_le);
      {r.q3, r.q2, r.q1, r.q0} = hash_le;
      return r;
   endfunction

   // receiver: stall at random unless a quiet stretch is on
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !quiet && ($urandom_range(0, 99) < 10);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      nonce_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result: nonce %h", $time, rsp_nonce_echo);
            errors++;
         end else begin
            e = pending_results.pop_front();
            checked++;
            found_count += e.found;
            bad_count += e.target_bad;
            if (rsp_nonce_echo !== e.nonce) begin
               $display("%0t nonce_echo exp %h got %h", $time, e.nonce, rsp_nonce_echo);
               errors++;
            end
            if (rsp_found !== e.found) begin
               $display("%0t found exp %b got %b (nonce %h)", $time, e.found, rsp_found,
                        e.nonce);
               errors++;
            end
            if (rsp_target_bad !== e.target_bad) begin
               $display("%0t target_bad exp %b got %b", $time, e.target_bad, rsp_target_bad);
               errors++;
            end
            if ({rsp_hash_q3, rsp_hash_q2, rsp_hash_q1, rsp_hash_q0} !==
                {e.q3, e.q2, e.q1, e.q0}) begin
               $display("%0t hash exp %h%h%h%h", $time, e.q3, e.q2, e.q1, e.q0);
               $display("%0t      got %h%h%h%h", $time, rsp_hash_q3, rsp_hash_q2,
                        rsp_hash_q1, rsp_hash_q0);
               errors++;
            end
         end
      end
   end

   task automatic send_nonce(bit [31:0] nonce);
      int gap;
      gap = (!quiet && $urandom_range(0, 99) < 10) ? $urandom_range(1, 4) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_nonce <= nonce;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(scan_nonce(nonce));
   endtask

   // hold off until every result is back, then let the pipeline empty
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] index, bit [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_MIDSTATE_A: midstate_regs[0] = data;
         CSR_MIDSTATE_B: midstate_regs[1] = data;
         CSR_MIDSTATE_C: midstate_regs[2] = data;
         CSR_MIDSTATE_D: midstate_regs[3] = data;
         CSR_HEADER_TAIL: tail_reg = data;
         CSR_COMPACT_TARGET: target_bits = data[31:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_header(bit [63:0] a, bit [63:0] b, bit [63:0] c, bit [63:0] d,
                              bit [63:0] tail, bit [63:0] bits);
      write_csr(CSR_MIDSTATE_A, a);
      write_csr(CSR_MIDSTATE_B, b);
      write_csr(CSR_MIDSTATE_C, c);
      write_csr(CSR_MIDSTATE_D, d);
      write_csr(CSR_HEADER_TAIL, tail);
      write_csr(CSR_COMPACT_TARGET, bits);
   endtask

   function automatic bit [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic test_reset_defaults();
      send_nonce(32'h0000_0000);
      send_nonce(32'hffff_ffff);
      send_nonce(32'h8000_0001);
      wait_drained();
   endtask

   task automatic test_header_extremes();
      load_header('1, '1, '1, '1, '1, 64'h0000_0000_ffff_ffff);
      send_nonce(32'h0000_0000);
      send_nonce(32'hffff_ffff);
      wait_drained();
      load_header(rand64(), rand64(), rand64(), rand64(), rand64(), 64'h1d00_ffff);
      for (int i = 0; i < 32; i += 8) send_nonce(32'h1 << i);
      send_nonce(32'h5555_aaaa);
      wait_drained();
   endtask

   // exponent below and above the legal range, zero mantissa, bit 23 set,
   // widest and narrowest shifts, and an easy target where found is common
   task automatic test_target_forms();
      bit [31:0] forms [9] = '{32'h0200_ffff, 32'h0300_0001, 32'h0380_0000, 32'h2000_0000,
                               32'h207f_ffff, 32'h20ff_ffff, 32'h2100_ffff, 32'hff7f_ffff,
                               32'h0000_0000};
      foreach (forms[k]) begin
         write_csr(CSR_COMPACT_TARGET, {$urandom(), forms[k]});
         send_nonce($urandom());
         send_nonce($urandom());
         wait_drained();
      end
      // unused indexes must leave the register file alone
      write_csr(CSR_UNUSED_6, rand64());
      write_csr(CSR_UNUSED_7, rand64());
      send_nonce($urandom());
      wait_drained();
   endtask

   task automatic test_random_scan(int phases, int per_phase);
      bit [31:0] bits;
      for (int p = 0; p < phases; p++) begin
         case ($urandom_range(0, 3))
            0: bits = {8'h20, 24'($urandom())};
            1: bits = {8'h1f + 8'($urandom_range(0, 1)), 24'($urandom())};
            2: bits = $urandom();
            default: bits = {8'($urandom_range(3, 32)), 24'($urandom())};
         endcase
         if (bits[31:24] == 8'h20 && $urandom_range(0, 1)) bits[22:0] = 23'h7fffff;
         load_header(rand64(), rand64(), rand64(), rand64(), rand64(), {$urandom(), bits});
         quiet = (p == 1);
         for (int n = 0; n < per_phase; n++) send_nonce($urandom());
         quiet = 0;
         wait_drained();
      end
   endtask

   task automatic test_back_to_back_after_pause();
      for (int n = 0; n < 40; n++) send_nonce($urandom());
      wait_drained();
      for (int n = 0; n < 40; n++) send_nonce($urandom());
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_nonce = '0;
      csr_valid = 1'b0;
      csr_index = CSR_MIDSTATE_A;
      csr_wdata = '0;
      foreach (midstate_regs[i]) midstate_regs[i] = '0;
      tail_reg = '0;
      target_bits = 32'h1d00_ffff;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_header_extremes();
      test_target_forms();
      test_random_scan(10, 110);
      test_back_to_back_after_pause();
      wait_drained();

      $display("Checked %0d hash results over many header and target settings;", checked);
      $display("%0d met the target, %0d had an out-of-range exponent.", found_count, bad_count);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
